// File: hw/rtl/mfd_pkg.sv
`default_nettype none

package mfd_pkg;

    localparam int MAX_DISTINCT = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One table slot as it moves along the chain.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_entry;

    // Chain operation for the current cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ABSORB,
        OP_SHIFT,
        OP_CLEAR
    } t_op;

    typedef enum logic {
        S_ABSORB,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] key;
        logic [COUNT_W-1:0] highest;
    } t_chain_ctl;

    typedef struct packed {
        logic   match_any;
        logic   sat_any;
        logic   bump_any;
        logic   insert;
        logic   full;
        logic   others_qual;
        t_entry top;
    } t_chain_sts;

endpackage

`default_nettype wire

// File: hw/rtl/mfd_cell.sv
`default_nettype none

module mfd_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  mfd_pkg::t_op            i_op,
    input  wire [31:0]              i_key,
    input  wire [15:0]              i_highest,
    input  wire                     i_insert,
    input  mfd_pkg::t_entry         i_left,
    input  wire                     i_left_ge,
    output mfd_pkg::t_entry         o_entry,
    output logic                    o_ge,
    output logic                    o_eq,
    output logic                    o_sat,
    output logic                    o_bump,
    output logic                    o_qual
);
    import mfd_pkg::*;

    logic               r_valid;
    logic [VALUE_W-1:0] r_value;
    logic [COUNT_W-1:0] r_count;
    logic               n_valid;
    logic [VALUE_W-1:0] n_value;
    logic [COUNT_W-1:0] n_count;

    // Slot at or past the insert point: empty, or holds a value not below the key.
    assign o_ge   = !r_valid || ($signed(r_value) >= $signed(i_key));
    assign o_eq   = r_valid && (r_value == i_key);
    assign o_sat  = o_eq && (r_count == COUNT_MAX);
    assign o_bump = o_eq && !o_sat && (r_count == i_highest);
    assign o_qual = r_valid && (r_count == i_highest);

    assign o_entry.valid = r_valid;
    assign o_entry.value = r_value;
    assign o_entry.count = r_count;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_count = r_count;
        case (i_op)
            OP_ABSORB: begin
                if (o_eq) begin
                    if (!o_sat) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end else if (i_insert) begin
                    if (i_left_ge) begin
                        // make room: take the neighbor's slot
                        n_valid = i_left.valid;
                        n_value = i_left.value;
                        n_count = i_left.count;
                    end else if (o_ge) begin
                        n_valid = 1'b1;
                        n_value = i_key;
                        n_count = COUNT_W'(1);
                    end
                end
            end
            OP_SHIFT: begin
                n_valid = i_left.valid;
                n_value = i_left.value;
                n_count = i_left.count;
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_count <= n_count;
    end

endmodule

`default_nettype wire

// File: hw/rtl/mfd_chain.sv
`default_nettype none

module mfd_chain (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mfd_pkg::t_chain_ctl  i_ctl,
    output mfd_pkg::t_chain_sts  o_sts
);
    import mfd_pkg::*;

    t_entry                  w_entry [MAX_DISTINCT];
    t_entry                  w_left  [MAX_DISTINCT];
    logic [MAX_DISTINCT-1:0] w_ge;
    logic [MAX_DISTINCT-1:0] w_left_ge;
    logic [MAX_DISTINCT-1:0] w_eq;
    logic [MAX_DISTINCT-1:0] w_sat;
    logic [MAX_DISTINCT-1:0] w_bump;
    logic [MAX_DISTINCT-1:0] w_qual;
    logic                    w_insert;

    assign w_insert = !(|w_eq) && !w_entry[MAX_DISTINCT-1].valid;

    for (genvar g = 0; g < MAX_DISTINCT; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g]    = '0;
            assign w_left_ge[g] = 1'b0;
        end else begin : g_link
            assign w_left[g]    = w_entry[g-1];
            assign w_left_ge[g] = w_ge[g-1];
        end

        mfd_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (i_ctl.op),
            .i_key     (i_ctl.key),
            .i_highest (i_ctl.highest),
            .i_insert  (w_insert),
            .i_left    (w_left[g]),
            .i_left_ge (w_left_ge[g]),
            .o_entry   (w_entry[g]),
            .o_ge      (w_ge[g]),
            .o_eq      (w_eq[g]),
            .o_sat     (w_sat[g]),
            .o_bump    (w_bump[g]),
            .o_qual    (w_qual[g])
        );
    end

    assign o_sts.match_any   = |w_eq;
    assign o_sts.sat_any     = |w_sat;
    assign o_sts.bump_any    = |w_bump;
    assign o_sts.insert      = w_insert;
    assign o_sts.full        = w_entry[MAX_DISTINCT-1].valid;
    assign o_sts.others_qual = |w_qual[MAX_DISTINCT-2:0];
    assign o_sts.top         = w_entry[MAX_DISTINCT-1];

`ifndef SYNTHESIS
    // Stored values are distinct, so a key matches at most one slot.
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_eq))
        else $error("key matches more than one slot");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/mode_finder_descending_top.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_stall     i_sample_value, i_set_end
// result    out        o_out_valid / i_out_stall   o_mode_value, o_mode_count,
//                                                  o_final_mode, o_dropped
//
// Each request is absorbed by a sorted insertion chain of MAX_DISTINCT cells;
// requests stream back to back within a set. After the closing request the
// chain shifts toward its top cell in each cycle with a free output slot; the
// smallest mode is loaded last, the request side stalled.
// Reset (synchronous, active low) empties the chain, no clearing pass.
// A stalled result holds in the output register; the chain holds with it.

module mode_finder_descending_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire signed [31:0]   i_sample_value,
    input  wire                 i_set_end,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic signed [31:0]  o_mode_value,
    output logic [15:0]         o_mode_count,
    output logic                o_final_mode,
    output logic                o_dropped
);
    import mfd_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [COUNT_W-1:0] r_highest;
    logic [COUNT_W-1:0] n_highest;
    logic               r_drop;
    logic               n_drop;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [VALUE_W-1:0] r_mode_value;
    logic [COUNT_W-1:0] r_mode_count;
    logic               r_final_mode;
    logic               r_dropped;

    t_chain_ctl w_ctl;
    t_chain_sts w_sts;
    logic       w_absorb;
    logic       w_slot_free;
    logic       w_shift_en;
    logic       w_load;
    logic       w_last_mode;

    mfd_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts)
    );

    assign w_absorb    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    // Top cell holds the largest remaining value; emit it when its count is the peak.
    assign w_load      = w_shift_en && w_sts.top.valid && (w_sts.top.count == r_highest);
    assign w_last_mode = w_load && !w_sts.others_qual;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ABSORB: begin
                if (w_absorb && i_set_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_last_mode) begin
                    n_state = S_ABSORB;
                end
            end
            default: begin
                n_state = S_ABSORB;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_stall    = 1'b1;
        w_shift_en    = 1'b0;
        w_ctl.op      = OP_HOLD;
        w_ctl.key     = $unsigned(i_sample_value);
        w_ctl.highest = r_highest;
        case (r_state)
            S_ABSORB: begin
                o_in_stall = 1'b0;
                if (w_absorb) begin
                    w_ctl.op = OP_ABSORB;
                end
            end
            S_EMIT: begin
                w_shift_en = w_slot_free;
                if (w_last_mode) begin
                    // smallest mode leaves: drop the rest of the table
                    w_ctl.op = OP_CLEAR;
                end else if (w_slot_free) begin
                    w_ctl.op = OP_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    // Peak count and sticky drop flag
    always_comb begin
        n_highest = r_highest;
        n_drop    = r_drop;
        if (w_absorb) begin
            if (w_sts.bump_any || (w_sts.insert && (r_highest == '0))) begin
                n_highest = r_highest + COUNT_W'(1);
            end
            if (w_sts.sat_any || (!w_sts.match_any && w_sts.full)) begin
                n_drop = 1'b1;
            end
        end else if (w_last_mode) begin
            n_highest = '0;
            n_drop    = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ABSORB;
            r_highest   <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_highest   <= n_highest;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mode_value <= w_sts.top.value;
            r_mode_count <= r_highest;
            r_final_mode <= !w_sts.others_qual;
            r_dropped    <= r_drop;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode_value = $signed(r_mode_value);
    assign o_mode_count = r_mode_count;
    assign o_final_mode = r_final_mode;
    assign o_dropped    = r_dropped;

`ifndef SYNTHESIS
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_mode |=> (r_state == S_ABSORB) && (r_highest == '0) && !r_drop)
        else $error("set state not cleared after smallest mode");

    a_emit_has_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_highest != '0))
        else $error("emission with zero peak count");

    a_nonfinal_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_final_mode) |-> (r_state == S_EMIT))
        else $error("non-final result pending outside emission");

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_state == S_EMIT) && w_sts.top.valid)
        else $error("result load without valid top cell");
`endif

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mfd_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 400;
    localparam int GAP_CAP     = 20;
    localparam int DRAIN_WAIT  = MAX_DISTINCT + 8;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One expected mode as it should leave the result channel.
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
        logic                      last_mode;
        logic                      dropped;
    } t_mode_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [VALUE_W-1:0] i_sample_value;
    logic                      i_set_end;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [VALUE_W-1:0] o_mode_value;
    logic [COUNT_W-1:0]        o_mode_count;
    logic                      o_final_mode;
    logic                      o_dropped;

    // Histogram of the set in progress, kept sorted by signed value.
    logic signed [VALUE_W-1:0] seen_value [MAX_DISTINCT];
    logic [COUNT_W-1:0]        seen_count [MAX_DISTINCT];
    int                        seen_used;
    logic [COUNT_W-1:0]        peak_count;
    logic                      set_dropped;

    t_mode_result modes_due[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_token;
    int fail_count;
    int requests_sent;
    int sets_closed;
    int modes_checked;
    int cycle_count;

    mode_finder_descending_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_set_end      (i_set_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_mode_value   (o_mode_value),
        .o_mode_count   (o_mode_count),
        .o_final_mode   (o_final_mode),
        .o_dropped      (o_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Fold one accepted sample into the histogram. On the closing sample,
    // queue every value at the peak count, largest value first, then
    // empty the histogram for the next set.
    function automatic void tally_sample(logic signed [VALUE_W-1:0] v, logic closing);
        int           pos;
        int           k;
        int           n_modes;
        bit           counted;
        t_mode_result r;
        pos     = 0;
        counted = 1'b1;
        while (pos < seen_used && seen_value[pos] < v) pos++;
        if (pos < seen_used && seen_value[pos] == v) begin
            // Saturate rather than wrap; flag the lost occurrence.
            if (seen_count[pos] == COUNT_MAX) set_dropped = 1'b1;
            else seen_count[pos] = seen_count[pos] + 1'b1;
        end else if (seen_used >= MAX_DISTINCT) begin
            // No room for a new distinct value: drop it.
            set_dropped = 1'b1;
            counted     = 1'b0;
        end else begin
            for (int i = seen_used; i > pos; i--) begin
                seen_value[i] = seen_value[i-1];
                seen_count[i] = seen_count[i-1];
            end
            seen_value[pos] = v;
            seen_count[pos] = COUNT_W'(1);
            seen_used++;
        end
        if (counted && seen_count[pos] > peak_count) peak_count = seen_count[pos];
        if (!closing) return;

        n_modes = 0;
        for (int e = 0; e < seen_used; e++)
            if (seen_count[e] == peak_count && peak_count != 0) n_modes++;
        k = 0;
        for (int e = seen_used - 1; e >= 0; e--) begin
            if (seen_count[e] == peak_count && peak_count != 0) begin
                r.value     = seen_value[e];
                r.count     = peak_count;
                r.last_mode = (k == n_modes - 1);
                r.dropped   = set_dropped;
                modes_due.insert(modes_due.size(), r);
                k++;
            end
        end
        for (int e = 0; e < MAX_DISTINCT; e++) seen_count[e] = '0;
        seen_used   = 0;
        peak_count  = '0;
        set_dropped = 1'b0;
        sets_closed++;
    endfunction

    // Offer one request and hold it until accepted. Valid stays high from
    // one request to the next unless a gap is drawn, so it is never lowered
    // and raised in the same step.
    task automatic send_sample(input logic signed [VALUE_W-1:0] v, input logic closing);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= v;
        i_set_end      <= closing;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tally_sample(v, closing);
        requests_sent++;
    endtask

    // Change idling between edges so the receiver sees it at a fixed edge.
    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(posedge i_clk);
    endtask

    // Extremes, ties, a lone sample, and alternating bit patterns.
    task automatic test_directed();
        send_sample(VAL_MIN, 1'b1);

        send_sample(VAL_MAX, 1'b0);
        send_sample(VAL_MIN, 1'b0);
        send_sample(VAL_MAX, 1'b0);
        send_sample(VAL_MIN, 1'b0);
        send_sample(32'sd0, 1'b1);

        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(-32'sd1, 1'b1);

        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shAAAA_AAAA, 1'b0);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shAAAA_AAAA, 1'b0);
        send_sample(VAL_MAX, 1'b1);

        send_sample(32'sd7, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd3, 1'b1);
    endtask

    // Fill the table with distinct values in shuffled order, offer one
    // distinct value too many (dropped), then close the set on a repeat.
    task automatic test_table_full();
        logic signed [VALUE_W-1:0] pool [MAX_DISTINCT];
        logic signed [VALUE_W-1:0] tmp;
        int                        j;
        for (int i = 0; i < MAX_DISTINCT; i++)
            pool[i] = VAL_MIN + i * 32'sh0400_0000 + $urandom_range(0, 32'h03FF_FFFF);
        for (int i = MAX_DISTINCT - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        for (int i = 0; i < MAX_DISTINCT; i++) send_sample(pool[i], 1'b0);
        send_sample(pool[0] ^ 32'sh0000_0001, 1'b0);
        send_sample(pool[$urandom_range(0, MAX_DISTINCT - 1)], 1'b1);
    endtask

    // Random sets: mostly a few clustered values for repeats and ties, some
    // extremes, some full-range values to toggle every bit.
    task automatic test_random_sets(input int budget);
        int                        sent;
        int                        len;
        int                        pick;
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] v;
        sent = 0;
        while (sent < budget) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
            base = $urandom;
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(99);
                if (pick < 55) v = base + $urandom_range(0, 3);
                else if (pick < 75) begin
                    case ($urandom_range(3))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = 32'sd0;
                        default: v = -32'sd1;
                    endcase
                end else v = $urandom;
                send_sample(v, i == len - 1);
            end
            sent += len;
        end
    endtask

    // Stall the result side for a long stretch while requests keep coming,
    // so emission blocks and the request side backs up.
    task automatic test_backpressure();
        @(negedge i_clk);
        hold_token++;
        @(posedge i_clk);
        for (int s = 0; s < 3; s++)
            for (int i = 0; i < 8; i++) send_sample($urandom_range(0, 5), i == 7);
    endtask

    // Result side: check each accepted mode, then draw the next stall.
    initial begin : result_side
        int           hold_taken;
        int           hold_left;
        t_mode_result want;
        hold_taken  = 0;
        hold_left   = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (modes_due.size() == 0) begin
                    $error("unexpected mode: value %0d count %0d", o_mode_value, o_mode_count);
                    fail_count++;
                end else begin
                    want = modes_due.pop_front();
                    modes_checked++;
                    if (o_mode_value !== want.value) begin
                        $error("mode_value: expected %0d, got %0d", want.value, o_mode_value);
                        fail_count++;
                    end
                    if (o_mode_count !== want.count) begin
                        $error("mode_count: expected %0d, got %0d", want.count, o_mode_count);
                        fail_count++;
                    end
                    if (o_final_mode !== want.last_mode) begin
                        $error("final_mode: expected %0b, got %0b",
                               want.last_mode, o_final_mode);
                        fail_count++;
                    end
                    if (o_dropped !== want.dropped) begin
                        $error("dropped: expected %0b, got %0b", want.dropped, o_dropped);
                        fail_count++;
                    end
                end
            end
            if (hold_taken != hold_token) begin
                hold_taken = hold_token;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin : watchdog
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        seen_used      = 0;
        peak_count     = '0;
        set_dropped    = 1'b0;
        for (int e = 0; e < MAX_DISTINCT; e++) seen_count[e] = '0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_token     = 0;
        fail_count     = 0;
        requests_sent  = 0;
        sets_closed    = 0;
        modes_checked  = 0;

        // Hold reset with every input at a known value.
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_sample_value <= '0;
        i_set_end      <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily.
        set_idling(24, 79);
        test_directed();
        test_table_full();
        test_random_sets(25);

        // Swap the idling.
        set_idling(79, 24);
        test_directed();
        test_random_sets(25);

        // Full rate both ways.
        set_idling(0, 0);
        test_backpressure();
        test_random_sets(25);

        // Drop valid, drain the result queue, then allow the tail latency.
        i_in_valid <= 1'b0;
        while (modes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d requests in %0d sets; checked %0d modes", requests_sent,
                 sets_closed, modes_checked);
        $display("Covered extremes, ties, full table with a dropped value, long result stall");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
